[hw/rtl/multipart_body_scanner_assert.svh]
// Assertion helpers for the multipart body scanner checker.
`ifndef MULTIPART_BODY_SCANNER_ASSERT_SVH
`define MULTIPART_BODY_SCANNER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define MBS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define MBS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that stays on through reset.
`define MBS_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mbs_pkg.sv]
`timescale 1ns / 1ps
package mbs_pkg;

   localparam int MAX_BOUNDARY = 80;
   localparam int WIN_DEPTH    = MAX_BOUNDARY + 2;
   localparam int LEN_W        = $clog2(MAX_BOUNDARY + 1);
   localparam int HOLD_W       = $clog2(WIN_DEPTH + 1);

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [1:0] MODE_BOUNDARY = 2'd0;
   localparam logic [1:0] MODE_HEADERS  = 2'd1;
   localparam logic [1:0] MODE_IMAGE    = 2'd2;
   localparam logic [1:0] MODE_DONE     = 2'd3;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_start;
   } req_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_valid;
      logic       image_started;
      logic       image_ended;
   } rsp_item_type;

   typedef logic [MAX_BOUNDARY-1:0][7:0] bnd_array_type;

   typedef struct packed {
      logic              push;
      logic              clear;
      logic [7:0]        data;
      logic [HOLD_W-1:0] hold;
   } win_ctl_type;

   typedef struct packed {
      logic       drain;
      logic [7:0] data;
      logic       match;
   } win_stat_type;

endpackage

[hw/rtl/mbs_parse.sv]
`timescale 1ns / 1ps
module mbs_parse
   import mbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_item_type  item,
   input  win_stat_type  stat,
   output win_ctl_type   ctl,
   output bnd_array_type bnd,
   output logic [LEN_W-1:0] blen,
   output logic          started
);

   logic [1:0]       mode_ff, mode_in, mode_cur;
   logic [LEN_W-1:0] line_ff, line_in, line_cur;
   logic [LEN_W-1:0] blen_ff, blen_in, blen_cur;
   bnd_array_type    bnd_ff;
   logic             bnd_wr;
   logic [7:0]       c;

   always_comb begin
      c        = item.body_byte;
      mode_cur = item.body_start ? MODE_BOUNDARY : mode_ff;
      line_cur = item.body_start ? '0 : line_ff;
      blen_cur = item.body_start ? '0 : blen_ff;
      mode_in  = mode_ff;
      line_in  = line_ff;
      blen_in  = blen_ff;
      bnd_wr   = 1'b0;
      started  = 1'b0;
      ctl.push  = 1'b0;
      ctl.clear = 1'b0;
      ctl.data  = c;
      ctl.hold  = HOLD_W'(blen_ff) + HOLD_W'(2);
      if (step) begin
         mode_in = mode_cur;
         line_in = line_cur;
         blen_in = blen_cur;
         unique case (mode_cur)
            MODE_BOUNDARY: begin
               if (c == CH_LF) begin
                  blen_in = line_cur;
                  line_in = '0;
                  mode_in = MODE_HEADERS;
               end else if (c != CH_CR && line_cur < LEN_W'(MAX_BOUNDARY)) begin
                  bnd_wr  = 1'b1;
                  line_in = line_cur + LEN_W'(1);
               end
            end
            MODE_HEADERS: begin
               if (c == CH_LF) begin
                  if (line_cur == '0) begin
                     mode_in   = MODE_IMAGE;
                     started   = 1'b1;
                     ctl.clear = 1'b1;
                  end
                  line_in = '0;
               end else if (c != CH_CR && line_cur < LEN_W'(MAX_BOUNDARY)) begin
                  line_in = line_cur + LEN_W'(1);
               end
            end
            MODE_IMAGE: begin
               ctl.push = 1'b1;
               if (stat.match) begin
                  mode_in = MODE_DONE;
               end
            end
            MODE_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BOUNDARY;
         line_ff <= '0;
         blen_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         blen_ff <= blen_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_BOUNDARY; k++) begin
         if (bnd_wr && line_cur == LEN_W'(k)) begin
            bnd_ff[k] <= c;
         end
      end
   end

   assign bnd  = bnd_ff;
   assign blen = blen_ff;

endmodule

[hw/rtl/mbs_window.sv]
`timescale 1ns / 1ps
module mbs_window
   import mbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  win_ctl_type      ctl,
   input  bnd_array_type    bnd,
   input  logic [LEN_W-1:0] blen,
   output win_stat_type     stat
);

   logic [WIN_DEPTH-1:0][7:0] win_ff, win_in, win_shift;
   logic [HOLD_W-1:0]         fill_ff, fill_next;
   logic                      full;
   logic                      hit;

   always_comb begin
      full      = !(fill_ff < ctl.hold);
      fill_next = full ? ctl.hold : fill_ff + HOLD_W'(1);
      win_shift = {win_ff[WIN_DEPTH-1], win_ff[WIN_DEPTH-1:1]};
      for (int k = 0; k < WIN_DEPTH; k++) begin
         win_in[k] = (HOLD_W'(k) == ctl.hold - HOLD_W'(1)) ? ctl.data : win_shift[k];
      end
      hit = (win_in[0] == CH_CR) && (win_in[1] == CH_LF);
      for (int i = 0; i < MAX_BOUNDARY; i++) begin
         if (LEN_W'(i) < blen && win_in[i+2] != bnd[i]) begin
            hit = 1'b0;
         end
      end
      stat.drain = ctl.push && full;
      stat.data  = win_ff[0];
      stat.match = ctl.push && (fill_next == ctl.hold) && hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (ctl.clear || stat.match) begin
         fill_ff <= '0;
      end else if (ctl.push) begin
         fill_ff <= fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         win_ff <= win_in;
      end
   end

endmodule

[hw/rtl/multipart_body_scanner.sv]
`timescale 1ns / 1ps
// An accepted byte waits in the input register; its result goes to the output register once free.
// One byte per cycle while rsp_stall is low; input and output registers keep both sides moving.
// Bytes that produce no result are consumed without a transaction on the rsp channel.
// Reset (synchronous, active high) empties both registers and returns the scanner to
// boundary collection; boundary and window storage keep their contents and are rewritten.
module multipart_body_scanner
   import mbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic             in_valid_ff;
   req_item_type     in_item_ff;
   logic             out_valid_ff;
   rsp_item_type     out_item_ff;
   rsp_item_type     out_item_in;
   logic             out_free;
   logic             step;
   logic             started;
   win_ctl_type      ctl;
   win_stat_type     stat;
   bnd_array_type    bnd;
   logic [LEN_W-1:0] blen;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   mbs_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (in_item_ff),
      .stat    (stat),
      .ctl     (ctl),
      .bnd     (bnd),
      .blen    (blen),
      .started (started)
   );

   mbs_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .bnd   (bnd),
      .blen  (blen),
      .stat  (stat)
   );

   always_comb begin
      out_item_in.data_valid    = stat.drain;
      out_item_in.data_byte     = stat.drain ? stat.data : 8'h00;
      out_item_in.image_started = started;
      out_item_in.image_ended   = stat.match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= step && (out_item_in.data_valid || out_item_in.image_started
                                     || out_item_in.image_ended);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_item;
      end
      if (out_free) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

[hw/rtl/mbs_checker.sv]
`timescale 1ns / 1ps
`include "multipart_body_scanner_assert.svh"
module mbs_checker
   import mbs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   `MBS_ASSERT_IMP(a_rsp_has_flag, rsp_valid,
      rsp_item.data_valid || rsp_item.image_started || rsp_item.image_ended,
      "transaction without any flag")
   `MBS_ASSERT_IMP(a_idle_byte_zero, rsp_valid && !rsp_item.data_valid,
      rsp_item.data_byte == 8'h00, "data byte not zero without data")
   `MBS_ASSERT_IMP(a_start_alone, rsp_valid && rsp_item.image_started,
      !rsp_item.image_ended && !rsp_item.data_valid, "image start mixed with image data")
   `MBS_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_item), "stalled transaction changed")
   `MBS_ASSERT_RST(a_reset_clear, reset, !rsp_valid && !req_stall, "channels busy after reset")

endmodule

bind multipart_body_scanner mbs_checker u_mbs_checker (.*);

[test/multipart_body_scanner_tb.sv]
`timescale 1ns / 1ps
module multipart_body_scanner_tb;
   import mbs_pkg::*;

   localparam int RANDOM_ITEMS = 950;
   localparam int QUIET_AFTER  = 850;
   localparam int DIR_COUNT    = 23;
   localparam rsp_item_type NO_RSP = '0;

   typedef struct packed {
      req_item_type item;
      logic         fixed;
      rsp_item_type res;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{'{8'h61, 1'b1}, 1'b0, NO_RSP},
      '{'{CH_CR, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h62, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_CR, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LF, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h58, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_CR, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LF, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_CR, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LF, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{'{8'h00, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hFF, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_CR, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LF, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h61, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{8'h62, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1}},
      '{'{CH_CR, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LF, 1'b1}, 1'b0, NO_RSP},
      '{'{CH_LF, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{'{8'h7A, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_CR, 1'b0}, 1'b0, NO_RSP},
      '{'{CH_LF, 1'b0}, 1'b1, '{8'h7A, 1'b1, 1'b0, 1'b1}},
      '{'{8'h55, 1'b0}, 1'b0, NO_RSP}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   logic [1:0]        sc_mode = MODE_BOUNDARY;
   logic [7:0]        bnd_mem [MAX_BOUNDARY];
   logic [LEN_W-1:0]  bnd_len = '0;
   logic [LEN_W-1:0]  line_len = '0;
   logic [7:0]        win_mem [WIN_DEPTH];
   logic [HOLD_W-1:0] win_fill = '0;

   rsp_item_type scan_results_q [$];
   int  errors = 0;
   int  rand_count = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;
   bit  idle_on = 1'b1;
   bit  start_next = 1'b0;

   multipart_body_scanner DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   function automatic bit scan_body_byte(input req_item_type it, output rsp_item_type res);
      logic [7:0]        c;
      logic [HOLD_W-1:0] hold;
      bit                hit;
      int                i;
      c = it.body_byte;
      res = '0;
      if (it.body_start) begin
         sc_mode = MODE_BOUNDARY;
         bnd_len = '0;
         line_len = '0;
         win_fill = '0;
      end
      case (sc_mode)
         MODE_BOUNDARY: begin
            if (c == CH_LF) begin
               bnd_len = line_len;
               line_len = '0;
               sc_mode = MODE_HEADERS;
            end else if (c != CH_CR && line_len < MAX_BOUNDARY) begin
               bnd_mem[line_len] = c;
               line_len = line_len + 1'b1;
            end
         end
         MODE_HEADERS: begin
            if (c == CH_LF) begin
               if (line_len == 0) begin
                  sc_mode = MODE_IMAGE;
                  win_fill = '0;
                  res.image_started = 1'b1;
               end
               line_len = '0;
            end else if (c != CH_CR && line_len < MAX_BOUNDARY) begin
               line_len = line_len + 1'b1;
            end
         end
         MODE_IMAGE: begin
            hold = bnd_len + 2;
            if (win_fill < hold) begin
               win_mem[win_fill] = c;
               win_fill = win_fill + 1'b1;
            end else begin
               res.data_byte = win_mem[0];
               res.data_valid = 1'b1;
               for (i = 0; i < hold - 1; i++) win_mem[i] = win_mem[i + 1];
               win_mem[hold - 1] = c;
            end
            hit = (win_fill == hold) && win_mem[0] == CH_CR && win_mem[1] == CH_LF;
            for (i = 0; i < bnd_len; i++) begin
               if (win_mem[i + 2] != bnd_mem[i]) hit = 1'b0;
            end
            if (hit) begin
               win_fill = '0;
               sc_mode = MODE_DONE;
               res.image_ended = 1'b1;
            end
         end
         default: ;
      endcase
      return res.data_valid | res.image_started | res.image_ended;
   endfunction

   function automatic logic [7:0] line_char();
      logic [7:0] b;
      if ($urandom_range(0, 15) == 0) return CH_CR;
      do b = 8'($urandom); while (b == CH_LF);
      return b;
   endfunction

   task automatic send_item(input logic [7:0] b, input bit counted = 1'b1,
                            input bit fixed = 1'b0, input rsp_item_type fixed_res = '0);
      req_item_type it;
      rsp_item_type res;
      bit           hit;
      int           gap;
      it.body_byte = b;
      it.body_start = start_next;
      start_next = 1'b0;
      gap = (!quiet && idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      hit = scan_body_byte(it, res);
      if (fixed) scan_results_q.push_back(fixed_res);
      else if (hit) scan_results_q.push_back(res);
      if (counted) rand_count++;
      if (rand_count >= QUIET_AFTER) quiet = 1'b1;
   endtask

   task automatic send_body();
      logic [7:0] bnd [$];
      logic [7:0] b;
      int         blen, nhdr, hlen, ilen, plen, k, j;
      start_next = 1'b1;
      idle_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(5, 30))
            send_item(($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom));
         return;
      end
      blen = ($urandom_range(0, 19) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 10);
      for (k = 0; k < blen; k++) begin
         b = line_char();
         send_item(b);
         if (b != CH_CR && bnd.size() < MAX_BOUNDARY) bnd.push_back(b);
      end
      if ($urandom_range(0, 1)) send_item(CH_CR);
      send_item(CH_LF);
      nhdr = $urandom_range(0, 3);
      for (k = 0; k < nhdr; k++) begin
         hlen = ($urandom_range(0, 15) == 0) ? $urandom_range(81, 95) : $urandom_range(1, 20);
         repeat (hlen) send_item(line_char());
         send_item(CH_CR);
         send_item(CH_LF);
      end
      send_item(CH_CR);
      send_item(CH_LF);
      ilen = $urandom_range(0, 30);
      for (k = 0; k < ilen; k++) begin
         if ($urandom_range(0, 11) == 0 && bnd.size() > 0) begin
            send_item(CH_CR);
            send_item(CH_LF);
            plen = $urandom_range(0, bnd.size() - 1);
            for (j = 0; j < plen; j++) send_item(bnd[j]);
         end else begin
            send_item(8'($urandom));
         end
      end
      if ($urandom_range(0, 7) != 0) begin
         send_item(CH_CR);
         send_item(CH_LF);
         foreach (bnd[j]) send_item(bnd[j]);
         repeat ($urandom_range(0, 3)) send_item(8'($urandom), 1'b0);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scan_results_q.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual byte %h valid %b start %b end %b",
                     $time, rsp_item.data_byte, rsp_item.data_valid,
                     rsp_item.image_started, rsp_item.image_ended);
            errors++;
         end else begin
            want = scan_results_q.pop_front();
            if (rsp_item.data_byte !== want.data_byte) begin
               $display("%0t data_byte: expected %h, actual %h",
                        $time, want.data_byte, rsp_item.data_byte);
               errors++;
            end
            if (rsp_item.data_valid !== want.data_valid) begin
               $display("%0t data_valid: expected %b, actual %b",
                        $time, want.data_valid, rsp_item.data_valid);
               errors++;
            end
            if (rsp_item.image_started !== want.image_started) begin
               $display("%0t image_started: expected %b, actual %b",
                        $time, want.image_started, rsp_item.image_started);
               errors++;
            end
            if (rsp_item.image_ended !== want.image_ended) begin
               $display("%0t image_ended: expected %b, actual %b",
                        $time, want.image_ended, rsp_item.image_ended);
               errors++;
            end
         end
      end
      if (stall_left > 0) stall_left = stall_left - 1;
      else if (!reset && !quiet && idle_on && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 4);
      rsp_stall <= (stall_left != 0);
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int r;
      int drain;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (r = 0; r < DIR_COUNT; r++) begin
         start_next = DIR_ROWS[r].item.body_start;
         send_item(DIR_ROWS[r].item.body_byte, 1'b0, DIR_ROWS[r].fixed, DIR_ROWS[r].res);
      end
      while (rand_count < RANDOM_ITEMS) send_body();
      req_valid <= 1'b0;
      drain = 0;
      while (scan_results_q.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (scan_results_q.size() != 0) begin
         $display("%0t missing transactions: expected %0d more, actual 0",
                  $time, scan_results_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
